/* hw/rtl/frcg_pkg.sv */
// shared types, constants and codes for the frame counter replay guard
`timescale 1ns / 1ps
`default_nettype none
package frcg_pkg;

  localparam int FRAME_OVERHEAD      = 28;
  localparam int MAX_PLAIN_BYTES     = 256;
  localparam int SECURE_BUFFER_BYTES = 512;

  localparam int CTR_W     = 64;
  localparam int SIZE_W    = 10;
  localparam int SUM_W     = SIZE_W + 1;
  localparam int REJ_W     = 32;
  localparam int WINDOW    = 64;
  localparam int WIN_IDX_W = $clog2(WINDOW);

  localparam logic [SUM_W-1:0] OVH_X      = SUM_W'(FRAME_OVERHEAD);
  localparam logic [SUM_W-1:0] MAX_X      = SUM_W'(MAX_PLAIN_BYTES);
  localparam logic [SUM_W-1:0] SBB_X      = SUM_W'(SECURE_BUFFER_BYTES);
  localparam logic [SUM_W:0]   BODY_LIM_X = (SUM_W + 1)'(MAX_PLAIN_BYTES + FRAME_OVERHEAD);

  localparam logic [7:0] MAGIC_A     = 8'h47;
  localparam logic [7:0] MAGIC_B     = 8'h53;
  localparam logic [7:0] FMT_VERSION = 8'h02;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_SEAL  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_SESSION = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_REPLAYED   = 3'd3,
    ST_BAD_SIZE   = 3'd4,
    ST_CRYPTO     = 3'd5,
    ST_EXHAUSTED  = 3'd6,
    ST_STALE      = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic              direction;
    logic [7:0]        magic_first;
    logic [7:0]        magic_second;
    logic [7:0]        format_version;
    logic [7:0]        header_direction;
    logic [CTR_W-1:0]  frame_counter;
    logic [SIZE_W-1:0] frame_size;
    logic [SIZE_W-1:0] plain_size;
    logic [CTR_W-1:0]  session_number;
    logic              crypto_ok;
  } in_t;

  typedef struct packed {
    logic              accepted;
    logic [2:0]        status;
    logic [CTR_W-1:0]  send_counter;
    logic [REJ_W-1:0]  rejected_total;
  } out_t;

  // result of one pass through the shared subtractor
  typedef struct packed {
    logic [CTR_W-1:0] diff;
    logic             eq;
    logic             lt;
  } alu_res_t;

endpackage
`default_nettype wire

/* hw/rtl/frcg_alu.sv */
// shared 64-bit subtract and compare unit
`timescale 1ns / 1ps
`default_nettype none
module frcg_alu (
  input  wire logic [frcg_pkg::CTR_W-1:0] a_i,
  input  wire logic [frcg_pkg::CTR_W-1:0] b_i,
  output frcg_pkg::alu_res_t              res_o
);

  logic [frcg_pkg::CTR_W:0] wide;

  // borrow out of the top bit is the unsigned less-than
  assign wide       = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff = wide[frcg_pkg::CTR_W-1:0];
  assign res_o.lt   = wide[frcg_pkg::CTR_W];
  assign res_o.eq   = (a_i == b_i);

endmodule
`default_nettype wire

/* hw/rtl/frcg_window.sv */
// replay test and bitmap update for the 64-frame sliding window
`timescale 1ns / 1ps
`default_nettype none
module frcg_window (
  input  wire logic [frcg_pkg::WINDOW-1:0] bitmap_i,
  input  wire logic                        ahead_i,
  input  wire logic                        ctr_zero_i,
  input  wire logic [frcg_pkg::CTR_W-1:0]  age_i,
  input  wire logic [frcg_pkg::CTR_W-1:0]  dist_i,
  output logic                             replay_o,
  output logic [frcg_pkg::WINDOW-1:0]      bitmap_o
);

  logic age_far;
  logic dist_far;
  logic seen_bit;

  assign age_far  = |age_i[frcg_pkg::CTR_W-1:frcg_pkg::WIN_IDX_W];
  assign dist_far = |dist_i[frcg_pkg::CTR_W-1:frcg_pkg::WIN_IDX_W];
  assign seen_bit = bitmap_i[age_i[frcg_pkg::WIN_IDX_W-1:0]];

  assign replay_o = ctr_zero_i || (!ahead_i && (age_far || seen_bit));

  always_comb begin
    if (ahead_i) begin
      // new top of window, slide the history up
      if (dist_far) begin
        bitmap_o = frcg_pkg::WINDOW'(1);
      end else begin
        bitmap_o = (bitmap_i << dist_i[frcg_pkg::WIN_IDX_W-1:0]) | frcg_pkg::WINDOW'(1);
      end
    end else begin
      bitmap_o = bitmap_i | (frcg_pkg::WINDOW'(1) << age_i[frcg_pkg::WIN_IDX_W-1:0]);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/frame_counter_replay_guard_top.sv */
// frame counter and anti-replay engine: sequencer, state and output register
// sequence: open goes through compare, age, check and, when rejected, a reject count pass;
//   seal, start and undefined opcodes go through compare and check; done then loads the output
// one word at a time, taken only in idle; every 64-bit ordering compare, age, increment and the
//   reject count update go one after another through the single shared subtractor
// reset: synchronous active-low rst_n clears the session, send counters (to one), windows
//   and reject count; in_ready is high the first cycle after reset is released
`timescale 1ns / 1ps
`default_nettype none
module frame_counter_replay_guard_top (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire frcg_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output frcg_pkg::out_t       out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_AGE,
    S_CHK,
    S_RCNT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  frcg_pkg::in_t     item_r, item_nxt;
  frcg_pkg::alu_res_t cmp_r, cmp_nxt;
  logic [frcg_pkg::CTR_W-1:0] age_r, age_nxt;
  logic [2:0]                 status_r, status_nxt;
  logic [frcg_pkg::CTR_W-1:0] issued_r, issued_nxt;

  logic [frcg_pkg::CTR_W-1:0]  active_r, active_nxt;
  logic [frcg_pkg::CTR_W-1:0]  nsc_r [2];
  logic [frcg_pkg::CTR_W-1:0]  nsc_nxt [2];
  logic [frcg_pkg::CTR_W-1:0]  top_r [2];
  logic [frcg_pkg::CTR_W-1:0]  top_nxt [2];
  logic [frcg_pkg::WINDOW-1:0] bm_r [2];
  logic [frcg_pkg::WINDOW-1:0] bm_nxt [2];
  logic [frcg_pkg::REJ_W-1:0]  rej_r, rej_nxt;

  logic           out_valid_r, out_valid_nxt;
  frcg_pkg::out_t out_data_r, out_data_nxt;

  logic [frcg_pkg::CTR_W-1:0] alu_a;
  logic [frcg_pkg::CTR_W-1:0] alu_b;
  frcg_pkg::alu_res_t         alu_res;

  logic                        dir;
  logic                        ahead;
  logic                        replay;
  logic [frcg_pkg::WINDOW-1:0] bm_upd;
  logic [frcg_pkg::SUM_W-1:0]  fsize_x;
  logic [frcg_pkg::SUM_W-1:0]  psize_x;
  logic                        header_ok;
  logic                        no_session;
  logic [2:0]                  chk_status;

  assign dir        = item_r.direction;
  assign ahead      = !cmp_r.lt && !cmp_r.eq;
  assign fsize_x    = frcg_pkg::SUM_W'(item_r.frame_size);
  assign psize_x    = frcg_pkg::SUM_W'(item_r.plain_size);
  assign no_session = (active_r == '0);
  assign header_ok  = (item_r.magic_first == frcg_pkg::MAGIC_A) &&
                      (item_r.magic_second == frcg_pkg::MAGIC_B) &&
                      (item_r.format_version == frcg_pkg::FMT_VERSION) &&
                      (item_r.header_direction == {7'd0, dir});

  frcg_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  frcg_window u_window (
    .bitmap_i   (bm_r[dir]),
    .ahead_i    (ahead),
    .ctr_zero_i (item_r.frame_counter == '0),
    .age_i      (age_r),
    .dist_i     (cmp_r.diff),
    .replay_o   (replay),
    .bitmap_o   (bm_upd)
  );

  // operand select for the shared subtractor
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_r)
      S_CMP: begin
        case (item_r.opcode)
          frcg_pkg::OP_OPEN: begin
            alu_a = item_r.frame_counter;
            alu_b = top_r[dir];
          end
          frcg_pkg::OP_SEAL: begin
            // minus all ones is plus one; eq flags exhaustion
            alu_a = nsc_r[dir];
            alu_b = '1;
          end
          frcg_pkg::OP_START: begin
            alu_a = item_r.session_number;
            alu_b = active_r;
          end
          default: begin
            alu_a = '0;
            alu_b = '0;
          end
        endcase
      end
      S_AGE: begin
        alu_a = top_r[dir];
        alu_b = item_r.frame_counter;
      end
      S_RCNT: begin
        alu_a = frcg_pkg::CTR_W'(rej_r);
        alu_b = '1;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  // decision from registered compare results
  always_comb begin
    chk_status = frcg_pkg::ST_BAD_HEADER;
    case (item_r.opcode)
      frcg_pkg::OP_OPEN: begin
        if (no_session) begin
          chk_status = frcg_pkg::ST_NO_SESSION;
        end else if (fsize_x <= frcg_pkg::OVH_X || fsize_x > frcg_pkg::SBB_X) begin
          chk_status = frcg_pkg::ST_BAD_SIZE;
        end else if (!header_ok) begin
          chk_status = frcg_pkg::ST_BAD_HEADER;
        end else if (replay) begin
          chk_status = frcg_pkg::ST_REPLAYED;
        end else if ({1'b0, fsize_x} > frcg_pkg::BODY_LIM_X) begin
          chk_status = frcg_pkg::ST_BAD_SIZE;
        end else if (!item_r.crypto_ok) begin
          chk_status = frcg_pkg::ST_CRYPTO;
        end else begin
          chk_status = frcg_pkg::ST_OK;
        end
      end
      frcg_pkg::OP_SEAL: begin
        if (no_session) begin
          chk_status = frcg_pkg::ST_NO_SESSION;
        end else if (psize_x == '0 || psize_x > frcg_pkg::MAX_X ||
                     ({1'b0, psize_x} + {1'b0, frcg_pkg::OVH_X}) > {1'b0, frcg_pkg::SBB_X}) begin
          chk_status = frcg_pkg::ST_BAD_SIZE;
        end else if (cmp_r.eq) begin
          chk_status = frcg_pkg::ST_EXHAUSTED;
        end else if (!item_r.crypto_ok) begin
          chk_status = frcg_pkg::ST_CRYPTO;
        end else begin
          chk_status = frcg_pkg::ST_OK;
        end
      end
      frcg_pkg::OP_START: begin
        if (item_r.session_number == '0 || cmp_r.lt || cmp_r.eq) begin
          chk_status = frcg_pkg::ST_STALE;
        end else if (!item_r.crypto_ok) begin
          chk_status = frcg_pkg::ST_CRYPTO;
        end else begin
          chk_status = frcg_pkg::ST_OK;
        end
      end
      default: begin
        chk_status = frcg_pkg::ST_BAD_HEADER;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cmp_nxt       = cmp_r;
    age_nxt       = age_r;
    status_nxt    = status_r;
    issued_nxt    = issued_r;
    active_nxt    = active_r;
    nsc_nxt       = nsc_r;
    top_nxt       = top_r;
    bm_nxt        = bm_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmp_nxt   = alu_res;
        state_nxt = (item_r.opcode == frcg_pkg::OP_OPEN) ? S_AGE : S_CHK;
      end
      S_AGE: begin
        age_nxt   = alu_res.diff;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        status_nxt = chk_status;
        issued_nxt = '0;
        state_nxt  = S_DONE;
        if (chk_status == frcg_pkg::ST_OK) begin
          case (item_r.opcode)
            frcg_pkg::OP_OPEN: begin
              bm_nxt[dir] = bm_upd;
              if (ahead) begin
                top_nxt[dir] = item_r.frame_counter;
              end
            end
            frcg_pkg::OP_SEAL: begin
              issued_nxt   = nsc_r[dir];
              nsc_nxt[dir] = cmp_r.diff;
            end
            frcg_pkg::OP_START: begin
              active_nxt = item_r.session_number;
              for (int i = 0; i < 2; i++) begin
                nsc_nxt[i] = frcg_pkg::CTR_W'(1);
                top_nxt[i] = '0;
                bm_nxt[i]  = '0;
              end
            end
            default: begin
              issued_nxt = '0;
            end
          endcase
        end else if (item_r.opcode == frcg_pkg::OP_OPEN) begin
          state_nxt = S_RCNT;
        end
      end
      S_RCNT: begin
        // saturating increment
        if (rej_r != '1) begin
          rej_nxt = alu_res.diff[frcg_pkg::REJ_W-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.accepted       = (status_r == frcg_pkg::ST_OK);
          out_data_nxt.status         = status_r;
          out_data_nxt.send_counter   = issued_r;
          out_data_nxt.rejected_total = rej_r;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cmp_r      <= cmp_nxt;
    age_r      <= age_nxt;
    status_r   <= status_nxt;
    issued_r   <= issued_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= '0;
      rej_r       <= '0;
      for (int i = 0; i < 2; i++) begin
        nsc_r[i] <= frcg_pkg::CTR_W'(1);
        top_r[i] <= '0;
        bm_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      rej_r       <= rej_nxt;
      nsc_r       <= nsc_nxt;
      top_r       <= top_nxt;
      bm_r        <= bm_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // reject count only moves in its own pass and never goes down
  a_rej_only_in_rcnt: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(state_r != S_RCNT) |-> $stable(rej_r))
    else $error("reject count changed outside its update pass");

  a_rej_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> rej_r >= $past(rej_r))
    else $error("reject count decreased");

  // a send counter of zero is never handed out
  a_nsc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (nsc_r[0] != '0) && (nsc_r[1] != '0))
    else $error("send counter reached zero");

  // a new result word is loaded only from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("output loaded outside done state");

endmodule
`default_nettype wire

/* tb/frame_counter_replay_guard_top_tb.sv */
// testbench for the frame counter replay guard: directed and random words checked against a predictor
`timescale 1ns / 1ps
module frame_counter_replay_guard_top_tb;

  localparam int HOLD_LEN = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  frcg_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  frcg_pkg::out_t out_data;

  frame_counter_replay_guard_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted guard state
  logic [63:0] gd_session;
  logic [63:0] gd_next_tx [2];
  logic [63:0] gd_top_rx [2];
  logic [63:0] gd_seen_rx [2];
  logic [31:0] gd_rejects;

  frcg_pkg::out_t pending_decisions[$];
  frcg_pkg::out_t want_res;
  int   err_cnt = 0;
  int   snd_idle = 0;
  int   rcv_idle = 0;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   hold_left = 0;

  function automatic void clear_links();
    for (int k = 0; k < 2; k++) begin
      gd_next_tx[k] = 64'd1;
      gd_top_rx[k] = '0;
      gd_seen_rx[k] = '0;
    end
  endfunction

  function automatic frcg_pkg::out_t frame_decision(input frcg_pkg::in_t w);
    frcg_pkg::out_t r;
    frcg_pkg::status_t st;
    logic d;
    logic [63:0] ctr;
    logic [63:0] top;
    logic [63:0] age;
    logic [63:0] issued;
    logic replay;
    int fsz;
    int psz;
    d = w.direction;
    ctr = w.frame_counter;
    top = gd_top_rx[d];
    fsz = int'(w.frame_size);
    psz = int'(w.plain_size);
    issued = '0;
    st = frcg_pkg::ST_OK;
    case (w.opcode)
      frcg_pkg::OP_OPEN: begin
        replay = 1'b0;
        if (ctr == 64'd0) begin
          replay = 1'b1;
        end else if (ctr <= top) begin
          age = top - ctr;
          replay = (age >= 64'(frcg_pkg::WINDOW)) ? 1'b1 : gd_seen_rx[d][age[5:0]];
        end
        if (gd_session == 64'd0) st = frcg_pkg::ST_NO_SESSION;
        else if (fsz <= frcg_pkg::FRAME_OVERHEAD || fsz > frcg_pkg::SECURE_BUFFER_BYTES)
          st = frcg_pkg::ST_BAD_SIZE;
        else if (w.magic_first != frcg_pkg::MAGIC_A || w.magic_second != frcg_pkg::MAGIC_B ||
                 w.format_version != frcg_pkg::FMT_VERSION || w.header_direction != {7'd0, d})
          st = frcg_pkg::ST_BAD_HEADER;
        else if (replay) st = frcg_pkg::ST_REPLAYED;
        else if (fsz - frcg_pkg::FRAME_OVERHEAD > frcg_pkg::MAX_PLAIN_BYTES)
          st = frcg_pkg::ST_BAD_SIZE;
        else if (!w.crypto_ok) st = frcg_pkg::ST_CRYPTO;
        else if (ctr > top) begin
          // newer counter slides the window forward
          if (ctr - top >= 64'(frcg_pkg::WINDOW)) gd_seen_rx[d] = 64'd1;
          else gd_seen_rx[d] = (gd_seen_rx[d] << (ctr - top)) | 64'd1;
          gd_top_rx[d] = ctr;
        end else begin
          gd_seen_rx[d] = gd_seen_rx[d] | (64'd1 << (top - ctr));
        end
        if (st != frcg_pkg::ST_OK && gd_rejects != '1) gd_rejects = gd_rejects + 32'd1;
      end
      frcg_pkg::OP_SEAL: begin
        if (gd_session == 64'd0) st = frcg_pkg::ST_NO_SESSION;
        else if (psz == 0 || psz > frcg_pkg::MAX_PLAIN_BYTES ||
                 psz + frcg_pkg::FRAME_OVERHEAD > frcg_pkg::SECURE_BUFFER_BYTES)
          st = frcg_pkg::ST_BAD_SIZE;
        else if (gd_next_tx[d] == '1) st = frcg_pkg::ST_EXHAUSTED;
        else if (!w.crypto_ok) st = frcg_pkg::ST_CRYPTO;
        else begin
          issued = gd_next_tx[d];
          gd_next_tx[d] = gd_next_tx[d] + 64'd1;
        end
      end
      frcg_pkg::OP_START: begin
        if (w.session_number == 64'd0 || w.session_number <= gd_session)
          st = frcg_pkg::ST_STALE;
        else if (!w.crypto_ok) st = frcg_pkg::ST_CRYPTO;
        else begin
          clear_links();
          gd_session = w.session_number;
        end
      end
      default: st = frcg_pkg::ST_BAD_HEADER;
    endcase
    r.accepted = (st == frcg_pkg::ST_OK);
    r.status = st;
    r.send_counter = issued;
    r.rejected_total = gd_rejects;
    return r;
  endfunction

  // well-formed word; ctr doubles as the session number for a start
  function automatic frcg_pkg::in_t frame_word(frcg_pkg::opcode_t op, logic d,
                                               logic [63:0] ctr);
    frcg_pkg::in_t w;
    w = '0;
    w.opcode = op;
    w.direction = d;
    w.magic_first = frcg_pkg::MAGIC_A;
    w.magic_second = frcg_pkg::MAGIC_B;
    w.format_version = frcg_pkg::FMT_VERSION;
    w.header_direction = {7'd0, d};
    w.frame_counter = ctr;
    w.frame_size = 10'd60;
    w.plain_size = 10'd32;
    w.session_number = ctr;
    w.crypto_ok = 1'b1;
    return w;
  endfunction

  // mostly valid traffic steered by the predicted window, with some noise
  function automatic frcg_pkg::in_t rand_word();
    frcg_pkg::in_t w;
    logic [191:0] raw;
    logic d;
    logic [63:0] top;
    int pick;
    int i;
    d = 1'($urandom_range(0, 1));
    top = gd_top_rx[d];
    pick = $urandom_range(0, 99);
    w = frame_word(frcg_pkg::OP_OPEN, d, top + 64'd1);
    if (pick < 8) begin
      for (i = 0; i < 6; i++) raw[i*32 +: 32] = $urandom;
      w = frcg_pkg::in_t'(raw[$bits(frcg_pkg::in_t)-1:0]);
    end else if (pick < 12) begin
      w = frame_word(frcg_pkg::OP_START, d, gd_session + 64'($urandom_range(0, 3)));
      w.crypto_ok = ($urandom_range(0, 9) != 0);
    end else if (pick < 40) begin
      w.opcode = frcg_pkg::OP_SEAL;
      w.plain_size = ($urandom_range(0, 4) != 0)
          ? 10'($urandom_range(1, frcg_pkg::MAX_PLAIN_BYTES))
          : 10'($urandom);
      w.crypto_ok = ($urandom_range(0, 19) != 0);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick >= 50 && pick < 62) w.frame_counter = top + 64'($urandom_range(2, 70));
      else if (pick >= 62 && pick < 80)
        w.frame_counter = (top > 64'd70) ? top - 64'($urandom_range(0, 70))
                                         : 64'($urandom_range(1, 70));
      else if (pick >= 80 && pick < 84) w.frame_counter = {$urandom, $urandom};
      else if (pick >= 84 && pick < 86) w.frame_counter = '0;
      w.frame_size = ($urandom_range(0, 7) != 0)
          ? 10'($urandom_range(frcg_pkg::FRAME_OVERHEAD + 1,
                               frcg_pkg::FRAME_OVERHEAD + frcg_pkg::MAX_PLAIN_BYTES))
          : 10'($urandom);
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 3))
          0: w.magic_first = 8'($urandom);
          1: w.magic_second = 8'($urandom);
          2: w.format_version = 8'($urandom);
          default: w.header_direction = 8'($urandom);
        endcase
      end
      w.crypto_ok = ($urandom_range(0, 11) != 0);
    end
    return w;
  endfunction

  // entered and left just after a falling edge
  task automatic offer_word(input frcg_pkg::in_t w);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      pending_decisions = {pending_decisions, frame_decision(in_data)};
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_decisions.size() == 0) begin
        $error("result word with nothing pending: status %0d", out_data.status);
        err_cnt++;
      end else begin
        want_res = pending_decisions.pop_front();
        if (out_data.accepted !== want_res.accepted) begin
          $error("accepted: expected %0d, got %0d", want_res.accepted, out_data.accepted);
          err_cnt++;
        end
        if (out_data.status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, out_data.status);
          err_cnt++;
        end
        if (out_data.send_counter !== want_res.send_counter) begin
          $error("send_counter: expected %0h, got %0h",
                 want_res.send_counter, out_data.send_counter);
          err_cnt++;
        end
        if (out_data.rejected_total !== want_res.rejected_total) begin
          $error("rejected_total: expected %0d, got %0d",
                 want_res.rejected_total, out_data.rejected_total);
          err_cnt++;
        end
      end
    end
  end

  // receiver: random idling, or a long counted hold when requested
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_LEN;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  task automatic test_no_session();
    offer_word(frame_word(frcg_pkg::OP_OPEN, 1'b0, 64'd1));
    offer_word(frame_word(frcg_pkg::OP_SEAL, 1'b1, 64'd1));
    offer_word(frame_word(frcg_pkg::OP_NONE, 1'b0, 64'd1));
  endtask

  task automatic test_session_start();
    frcg_pkg::in_t w;
    offer_word(frame_word(frcg_pkg::OP_START, 1'b0, 64'd0));
    // largest session with key derivation failing leaves the state alone
    w = frame_word(frcg_pkg::OP_START, 1'b1, '1);
    w.crypto_ok = 1'b0;
    offer_word(w);
    offer_word(frame_word(frcg_pkg::OP_START, 1'b0, 64'd5));
    offer_word(frame_word(frcg_pkg::OP_START, 1'b1, 64'd5));
  endtask

  task automatic test_seal_checks();
    frcg_pkg::in_t w;
    w = frame_word(frcg_pkg::OP_SEAL, 1'b0, 64'd0);
    w.plain_size = 10'd0;
    offer_word(w);
    w.plain_size = 10'(frcg_pkg::MAX_PLAIN_BYTES);
    offer_word(w);
    w.plain_size = 10'(frcg_pkg::MAX_PLAIN_BYTES + 1);
    offer_word(w);
    w.plain_size = '1;
    offer_word(w);
    // failed encryption must not consume the counter
    w.plain_size = 10'd1;
    w.crypto_ok = 1'b0;
    offer_word(w);
    w.crypto_ok = 1'b1;
    w.direction = 1'b1;
    offer_word(w);
  endtask

  task automatic test_open_checks();
    frcg_pkg::in_t w;
    w = frame_word(frcg_pkg::OP_OPEN, 1'b0, 64'd1);
    w.frame_size = 10'(frcg_pkg::FRAME_OVERHEAD);
    offer_word(w);
    w.frame_size = '1;
    offer_word(w);
    w = frame_word(frcg_pkg::OP_OPEN, 1'b0, 64'd1);
    w.magic_first = 8'hFF;
    offer_word(w);
    w = frame_word(frcg_pkg::OP_OPEN, 1'b0, 64'd1);
    w.header_direction = 8'd1;
    offer_word(w);
    offer_word(frame_word(frcg_pkg::OP_OPEN, 1'b0, 64'd0));
    w = frame_word(frcg_pkg::OP_OPEN, 1'b0, 64'd1);
    w.frame_size = 10'(frcg_pkg::FRAME_OVERHEAD + 1);
    offer_word(w);
    offer_word(w);
    // body too long is only seen after the replay check
    w = frame_word(frcg_pkg::OP_OPEN, 1'b0, 64'd2);
    w.frame_size = 10'(frcg_pkg::SECURE_BUFFER_BYTES);
    offer_word(w);
    w = frame_word(frcg_pkg::OP_OPEN, 1'b0, 64'd2);
    w.crypto_ok = 1'b0;
    offer_word(w);
    w.crypto_ok = 1'b1;
    w.frame_size = 10'(frcg_pkg::FRAME_OVERHEAD + frcg_pkg::MAX_PLAIN_BYTES);
    offer_word(w);
  endtask

  task automatic test_window_edges();
    // jump past the window, then one past the oldest slot and the oldest slot itself
    offer_word(frame_word(frcg_pkg::OP_OPEN, 1'b0, 64'd100));
    offer_word(frame_word(frcg_pkg::OP_OPEN, 1'b0, 64'd36));
    offer_word(frame_word(frcg_pkg::OP_OPEN, 1'b0, 64'd37));
    offer_word(frame_word(frcg_pkg::OP_OPEN, 1'b1, '1));
    offer_word(frame_word(frcg_pkg::OP_OPEN, 1'b1, 64'd1));
    offer_word(frame_word(frcg_pkg::OP_START, 1'b0, 64'd9));
  endtask

  // counter exhaustion and reject saturation need 2^64 and 2^32 words: not reachable here
  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) == 0) wait_all_results();
      offer_word(rand_word());
    end
  endtask

  task automatic test_output_stall();
    int keep_idle;
    keep_idle = snd_idle;
    wait_all_results();
    snd_idle = 0;
    hold_req++;
    for (int n = 0; n < 40; n++) offer_word(rand_word());
    snd_idle = keep_idle;
  endtask

  initial begin
    gd_session = '0;
    gd_rejects = '0;
    clear_links();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    snd_idle = 19;
    rcv_idle = 59;
    test_no_session();
    test_session_start();
    test_seal_checks();
    test_open_checks();
    test_window_edges();
    test_random_traffic(380);
    snd_idle = 59;
    rcv_idle = 19;
    test_random_traffic(330);
    snd_idle = 0;
    rcv_idle = 0;
    test_output_stall();
    test_random_traffic(330);
    wait_all_results();
    repeat (12) @(negedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
